// File: rtl/satd_pkg.sv
// ----------------------------------------------------------------------------
// SATD package
// Shared widths, constants and types for the 16x16 Hadamard SATD block.
// ----------------------------------------------------------------------------
package satd_pkg;

	// Geometry: four lanes, each covering one group of four columns.
	localparam int LANE_COUNT    = 4;
	localparam int COLS_PER_LANE = 4;
	localparam int PIX_W         = 8;
	localparam int LANE_PIX_W    = COLS_PER_LANE * PIX_W;

	// Arithmetic widths.
	localparam int COEF_W     = 11;  // horizontally transformed coefficient, signed
	localparam int LANE_SUM_W = 14;  // per-lane half absolute sum of one row group
	localparam int ADD_W      = 16;  // sum of all lanes for one row group
	localparam int SUM_W      = 19;  // running SATD

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	localparam int DEFAULT_BLOCK_ROWS = 16;

	// Row position within a group of four; the last one triggers the vertical pass.
	localparam logic [1:0] POS_VERT = 2'd3;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [LANE_SUM_W-1:0] lane_sum_t;
	typedef lane_sum_t [LANE_COUNT-1:0] lane_sum_arr_t;

	// Control from the top level to each lane.
	typedef struct packed {
		logic       adv;     // pipeline advances this cycle
		logic       wr_en;   // store the stage-one row into the row buffer
		logic [1:0] wr_row;  // buffer row to write
	} lane_ctrl_t;

	// Control from the top level to the merging stage.
	typedef struct packed {
		logic adv;
		logic valid;  // stage two holds a row
		logic vert;   // stage two row closed a group of four
		logic last;   // stage two row is the last of the block
	} merge_ctrl_t;

endpackage

// File: rtl/satd_lane.sv
// ----------------------------------------------------------------------------
// SATD lane
// Differences, horizontal and vertical 4-point Hadamard for four columns.
// ----------------------------------------------------------------------------
module satd_lane (
	input  logic                               clk,
	input  satd_pkg::lane_ctrl_t               ctrl,
	input  logic [satd_pkg::LANE_PIX_W-1:0]    cur,
	input  logic [satd_pkg::LANE_PIX_W-1:0]    refp,
	output satd_pkg::lane_sum_t                lane_sum_s2
);

	localparam int N  = satd_pkg::COLS_PER_LANE;
	localparam int VW = satd_pkg::COEF_W + 1;
	localparam int AW = VW - 1;

	function automatic logic [AW-1:0] abs_v(input logic signed [VW-1:0] v);
		logic signed [VW-1:0] n;
		begin
			n = -v;
			abs_v = v[VW-1] ? n[AW-1:0] : v[AW-1:0];
		end
	endfunction

	satd_pkg::coef_t x    [N];
	satd_pkg::coef_t hrow [N];
	satd_pkg::coef_t hrow_s1   [N];
	satd_pkg::coef_t rowbuf_q  [3][N];
	logic [AW:0]             col_add [N];
	satd_pkg::lane_sum_t     lane_add;

	// Pixel differences, widened to coefficient width.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			x[i] = satd_pkg::coef_t'({{(satd_pkg::COEF_W - satd_pkg::PIX_W){1'b0}},
				cur[i*satd_pkg::PIX_W +: satd_pkg::PIX_W]})
				- satd_pkg::coef_t'({{(satd_pkg::COEF_W - satd_pkg::PIX_W){1'b0}},
				refp[i*satd_pkg::PIX_W +: satd_pkg::PIX_W]});
		end
	end

	// Horizontal butterfly across the four columns.
	always_comb begin
		hrow[0] = (x[0] + x[1]) + (x[2] + x[3]);
		hrow[1] = (x[0] - x[1]) + (x[2] - x[3]);
		hrow[2] = (x[0] + x[1]) - (x[2] + x[3]);
		hrow[3] = (x[0] - x[1]) - (x[2] - x[3]);
	end

	// Stage one register.
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			for (int i = 0; i < N; i++) hrow_s1[i] <= hrow[i];
		end
	end

	// Buffer for the first three rows of each group.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			for (int i = 0; i < N; i++) rowbuf_q[ctrl.wr_row][i] <= hrow_s1[i];
		end
	end

	// Vertical butterfly; half the absolute sum is max(|s0|,|s1|) + max(|d0|,|d1|).
	always_comb begin
		logic signed [VW-1:0] s0, d0, s1, d1;
		logic [AW-1:0] as0, as1, ad0, ad1, ms, md;
		lane_add = '0;
		for (int i = 0; i < N; i++) begin
			s0 = VW'(rowbuf_q[0][i]) + VW'(rowbuf_q[1][i]);
			d0 = VW'(rowbuf_q[0][i]) - VW'(rowbuf_q[1][i]);
			s1 = VW'(rowbuf_q[2][i]) + VW'(hrow_s1[i]);
			d1 = VW'(rowbuf_q[2][i]) - VW'(hrow_s1[i]);
			as0 = abs_v(s0);
			as1 = abs_v(s1);
			ad0 = abs_v(d0);
			ad1 = abs_v(d1);
			ms = (as0 > as1) ? as0 : as1;
			md = (ad0 > ad1) ? ad0 : ad1;
			col_add[i] = {1'b0, ms} + {1'b0, md};
			lane_add = lane_add + satd_pkg::LANE_SUM_W'(col_add[i]);
		end
	end

	// Stage two register.
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			lane_sum_s2 <= lane_add;
		end
	end

endmodule

// File: rtl/satd_merge.sv
// ----------------------------------------------------------------------------
// SATD merge
// Adds the lane sums, accumulates with saturation and holds the result.
// ----------------------------------------------------------------------------
module satd_merge (
	input  logic                         clk,
	input  logic                         arst_n,
	input  satd_pkg::merge_ctrl_t        ctrl,
	input  satd_pkg::lane_sum_arr_t      lane_sums,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [satd_pkg::SUM_W-1:0]   out_data
);

	logic [satd_pkg::SUM_W-1:0] sum_q;
	logic [satd_pkg::SUM_W-1:0] out_data_q;
	logic                       out_valid_q;
	logic [satd_pkg::ADD_W-1:0] add;
	logic [satd_pkg::SUM_W:0]   total;
	logic [satd_pkg::SUM_W-1:0] sum_next;

	// Combine the lanes and saturate the running sum.
	always_comb begin
		add = '0;
		for (int l = 0; l < satd_pkg::LANE_COUNT; l++) begin
			add = add + satd_pkg::ADD_W'(lane_sums[l]);
		end
		total = {1'b0, sum_q} + (satd_pkg::SUM_W + 1)'(add);
		if (!ctrl.vert) begin
			sum_next = sum_q;
		end else if (total > {1'b0, satd_pkg::SUM_MAX}) begin
			sum_next = satd_pkg::SUM_MAX;
		end else begin
			sum_next = total[satd_pkg::SUM_W-1:0];
		end
	end

	// Accumulator and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (ctrl.adv && ctrl.valid) begin
				if (ctrl.last) begin
					sum_q       <= '0;
					out_valid_q <= 1'b1;
				end else begin
					sum_q <= sum_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv && ctrl.valid && ctrl.last) begin
			out_data_q <= sum_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: rtl/satd_hadamard_16x16.sv
// ----------------------------------------------------------------------------
// 16x16 Hadamard SATD
// Timing: the total passes the stage-one, stage-two and result registers before m_tvalid rises.
// Throughput: one row per cycle; the four lanes and the merge stage are fully pipelined.
// The input stalls only while a finished total waits and the next one is ready to leave.
// Reset: arst_n clears the row counter, pipeline valids, accumulator and output valid.
// ----------------------------------------------------------------------------
module satd_hadamard_16x16 #(
	parameter int BLOCK_ROWS = satd_pkg::DEFAULT_BLOCK_ROWS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// From bit 0: cur_pixels_low, cur_pixels_high, ref_pixels_low, ref_pixels_high.
	input  logic [255:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// From bit 0: satd_total (19 bits), zero padding.
	output logic [23:0]  m_tdata
);

	localparam int RW = $clog2(BLOCK_ROWS);
	localparam int L  = satd_pkg::LANE_COUNT;
	localparam int PW = satd_pkg::LANE_PIX_W;

	logic [RW-1:0]           row_q;
	logic                    row_last;
	logic                    adv;
	logic                    accept;
	logic                    v_s1, v_s2;
	logic [1:0]              pos_s1;
	logic                    last_s1, last_s2, vert_s2;
	satd_pkg::lane_ctrl_t    lane_ctrl;
	satd_pkg::merge_ctrl_t   merge_ctrl;
	satd_pkg::lane_sum_arr_t lane_sums;
	logic [satd_pkg::SUM_W-1:0] satd_total;

	// Hold everything only when a final total cannot be delivered.
	assign adv      = !(v_s2 && last_s2 && m_tvalid && !m_tready);
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;
	assign row_last = (row_q == RW'(BLOCK_ROWS - 1));

	// Row counter and pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			pos_s1  <= '0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
			vert_s2 <= 1'b0;
		end else if (adv) begin
			if (accept) row_q <= row_last ? '0 : row_q + 1'b1;
			v_s1    <= accept;
			pos_s1  <= row_q[1:0];
			last_s1 <= row_last;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			vert_s2 <= v_s1 && (pos_s1 == satd_pkg::POS_VERT);
		end
	end

	always_comb begin
		lane_ctrl.adv    = adv;
		lane_ctrl.wr_en  = adv && v_s1 && (pos_s1 != satd_pkg::POS_VERT);
		lane_ctrl.wr_row = pos_s1;
		merge_ctrl.adv   = adv;
		merge_ctrl.valid = v_s2;
		merge_ctrl.vert  = vert_s2;
		merge_ctrl.last  = last_s2;
	end

	// One lane per group of four columns.
	for (genvar g = 0; g < L; g++) begin : g_lane
		satd_lane u_lane (
			.clk         (clk),
			.ctrl        (lane_ctrl),
			.cur         (s_tdata[g*PW +: PW]),
			.refp        (s_tdata[L*PW + g*PW +: PW]),
			.lane_sum_s2 (lane_sums[g])
		);
	end

	satd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (merge_ctrl),
		.lane_sums (lane_sums),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (satd_total)
	);

	assign m_tdata = {{(24 - satd_pkg::SUM_W){1'b0}}, satd_total};

endmodule
